[hdl/suim_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// suim_pkg
// Types, constants and codes shared by the unit interval measurement block.
// ----------------------------------------------------------------------------
package suim_pkg;

    localparam int MARKER_COUNT_BITS_DEF = 15;

    localparam int TIME_W     = 46;
    localparam int COUNT_IN_W = 15;
    localparam int UI_SHIFT   = 12;
    localparam int NUM_W      = TIME_W + UI_SHIFT;
    localparam int INTV_W     = 23;
    localparam int BOUND_W    = 25;
    localparam int LANES_W    = 4;
    localparam int SPEED_W    = 2;
    localparam int UI_W       = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [TIME_W-1:0]  ONE_SECOND_FX = 46'h3B9ACA000000;
    localparam logic [INTV_W-1:0]  TX_INTERVAL   = 23'd5406720;
    localparam logic [INTV_W-1:0]  RX_INTERVAL_S = 23'd168960;
    localparam logic [INTV_W-1:0]  RX_INTERVAL_L = 23'd5406720;
    localparam logic [BOUND_W-1:0] B10_MIN       = 25'h18CC73E;
    localparam logic [BOUND_W-1:0] B10_MAX       = 25'h18D98F5;
    localparam logic [BOUND_W-1:0] B25_MIN       = 25'h09EDC00;
    localparam logic [BOUND_W-1:0] B25_MAX       = 25'h09EE420;

    localparam logic [SPEED_W-1:0] SPEED_10G = 2'd0;
    localparam logic [SPEED_W-1:0] SPEED_25G = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SKIP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_KR_FEC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LANES_USED = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]     tx_time_first;
        logic [TIME_W-1:0]     tx_time_nth;
        logic [COUNT_IN_W-1:0] tx_count_first;
        logic [COUNT_IN_W-1:0] tx_count_nth;
        logic [TIME_W-1:0]     rx_time_first;
        logic [TIME_W-1:0]     rx_time_nth;
        logic [COUNT_IN_W-1:0] rx_count_first;
        logic [COUNT_IN_W-1:0] rx_count_nth;
    } t_in;

    typedef struct packed {
        logic [UI_W-1:0]     tx_unit_interval;
        logic [STATUS_W-1:0] tx_status;
        logic [UI_W-1:0]     rx_unit_interval;
        logic [STATUS_W-1:0] rx_status;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0]  delta;
        logic [INTV_W-1:0]  interval;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic [LANES_W-1:0] lanes;
    } t_chan_cmd;

    typedef struct packed {
        t_chan_cmd tx;
        t_chan_cmd rx;
    } t_job;

    typedef struct packed {
        logic [UI_W-1:0]     ui;
        logic [STATUS_W-1:0] status;
    } t_chan_res;

    typedef struct packed {
        logic busy;
        logic done;
    } t_chan_flags;

    typedef enum logic [2:0] {
        CH_IDLE,
        CH_MUL,
        CH_DIV_L,
        CH_LOAD_Q,
        CH_DIV_Q,
        CH_CHECK,
        CH_DONE
    } t_chan_state;

endpackage
`default_nettype wire

[hdl/suim_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// suim_front
// Classifies one snapshot pair: wrapped time and count deltas, marker
// intervals and range bounds for each direction.
// ----------------------------------------------------------------------------
module suim_front
    import suim_pkg::*;
#(
    parameter int MARKER_COUNT_BITS = MARKER_COUNT_BITS_DEF
) (
    input  wire t_in                        i_data,
    input  wire logic [SPEED_W-1:0]         i_speed_mode,
    input  wire logic                       i_rx_kr_fec,
    input  wire logic [LANES_W-1:0]         i_lanes_used,
    output t_job                            o_job,
    output logic [MARKER_COUNT_BITS:0]      o_tx_cnt,
    output logic [MARKER_COUNT_BITS:0]      o_rx_cnt
);

    localparam int CW = MARKER_COUNT_BITS + 1;
    localparam logic [CW-1:0] CMASK  = {1'b0, {MARKER_COUNT_BITS{1'b1}}};
    localparam logic [CW-1:0] PERIOD = {1'b1, {MARKER_COUNT_BITS{1'b0}}};

    function automatic logic [TIME_W-1:0] time_delta(
        input logic [TIME_W-1:0] t0,
        input logic [TIME_W-1:0] t1
    );
        logic [TIME_W:0] diff;
        diff = {1'b0, t1} - {1'b0, t0};
        if (diff[TIME_W] || diff == '0) begin
            return diff[TIME_W-1:0] + ONE_SECOND_FX;
        end
        return diff[TIME_W-1:0];
    endfunction

    function automatic logic [CW-1:0] count_delta(
        input logic [COUNT_IN_W-1:0] c0_in,
        input logic [COUNT_IN_W-1:0] c1_in
    );
        logic [CW-1:0] c0;
        logic [CW-1:0] c1;
        c0 = CW'(c0_in) & CMASK;
        c1 = CW'(c1_in) & CMASK;
        if (c1 <= c0) begin
            return c1 + PERIOD - c0;
        end
        return c1 - c0;
    endfunction

    logic [INTV_W-1:0]  tx_int;
    logic [INTV_W-1:0]  rx_int;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;

    always_comb begin
        case (i_speed_mode)
            SPEED_10G: begin
                tx_int = TX_INTERVAL;
                lo     = B10_MIN;
                hi     = B10_MAX;
            end
            SPEED_25G: begin
                tx_int = TX_INTERVAL;
                lo     = B25_MIN;
                hi     = B25_MAX;
            end
            default: begin
                tx_int = '0;
                lo     = '0;
                hi     = '0;
            end
        endcase
        rx_int = (i_speed_mode == SPEED_25G && i_rx_kr_fec) ? RX_INTERVAL_L : RX_INTERVAL_S;
    end

    always_comb begin
        o_job.tx.delta    = time_delta(i_data.tx_time_first, i_data.tx_time_nth);
        o_job.tx.interval = tx_int;
        o_job.tx.lo       = lo;
        o_job.tx.hi       = hi;
        o_job.tx.lanes    = i_lanes_used;
        o_job.rx.delta    = time_delta(i_data.rx_time_first, i_data.rx_time_nth);
        o_job.rx.interval = rx_int;
        o_job.rx.lo       = lo;
        o_job.rx.hi       = hi;
        o_job.rx.lanes    = i_lanes_used;
        o_tx_cnt = count_delta(i_data.tx_count_first, i_data.tx_count_nth);
        o_rx_cnt = count_delta(i_data.rx_count_first, i_data.rx_count_nth);
    end

endmodule
`default_nettype wire

[hdl/suim_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// suim_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module suim_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule
`default_nettype wire

[hdl/suim_chan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// suim_chan
// One direction: count times interval, divide by lanes, then the shifted
// time delta by that divisor on one bit-serial divider; range check.
// ----------------------------------------------------------------------------
module suim_chan
    import suim_pkg::*;
#(
    parameter int MARKER_COUNT_BITS = MARKER_COUNT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire t_chan_cmd                  i_cmd,
    input  wire logic [MARKER_COUNT_BITS:0] i_cnt,
    input  wire logic                       i_ack,
    output t_chan_flags                     o_flags,
    output t_chan_res                       o_res
);

    localparam int CW = MARKER_COUNT_BITS + 1;
    localparam int PW = CW + INTV_W;
    localparam int SW = $clog2(NUM_W);

    t_chan_state       r_state;
    t_chan_state       n_state;
    t_chan_cmd         r_cmd;
    logic [CW-1:0]     r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [PW-1:0]     r_rem;
    logic [PW-1:0]     r_den;
    logic [SW-1:0]     r_step;
    t_chan_res         r_res;

    logic [PW-1:0]     prod;
    logic [PW:0]       rem_sh;
    logic              ge;
    logic [PW:0]       rem_sub;

    assign prod    = r_cnt * r_cmd.interval;
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_state = r_state;
        case (r_state)
            CH_IDLE: begin
                if (i_start) begin
                    n_state = CH_MUL;
                end
            end
            CH_MUL: begin
                n_state = (r_cmd.lanes == '0) ? CH_DONE : CH_DIV_L;
            end
            CH_DIV_L: begin
                if (r_step == '0) begin
                    n_state = CH_LOAD_Q;
                end
            end
            CH_LOAD_Q: begin
                n_state = (r_num == '0) ? CH_DONE : CH_DIV_Q;
            end
            CH_DIV_Q: begin
                if (r_step == '0) begin
                    n_state = CH_CHECK;
                end
            end
            CH_CHECK: begin
                n_state = CH_DONE;
            end
            CH_DONE: begin
                if (i_ack) begin
                    n_state = CH_IDLE;
                end
            end
            default: begin
                n_state = CH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_flags.busy = (r_state != CH_IDLE);
        o_flags.done = (r_state == CH_DONE);
        o_res        = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CH_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CH_IDLE: begin
                r_cmd <= i_cmd;
                r_cnt <= i_cnt;
            end
            CH_MUL: begin
                r_num  <= NUM_W'(prod);
                r_den  <= PW'(r_cmd.lanes);
                r_rem  <= '0;
                r_step <= SW'(NUM_W - 1);
                r_res  <= '{ui: '0, status: ST_ZERO};
            end
            CH_DIV_L, CH_DIV_Q: begin
                r_rem  <= ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
                r_num  <= {r_num[NUM_W-2:0], ge};
                r_step <= r_step - SW'(1);
            end
            CH_LOAD_Q: begin
                r_den  <= r_num[PW-1:0];
                r_num  <= {r_cmd.delta, {UI_SHIFT{1'b0}}};
                r_rem  <= '0;
                r_step <= SW'(NUM_W - 1);
            end
            CH_CHECK: begin
                r_res.ui <= (|r_num[NUM_W-1:UI_W]) ? {UI_W{1'b1}} : r_num[UI_W-1:0];
                if (r_num > NUM_W'(r_cmd.hi) || r_num < NUM_W'(r_cmd.lo)) begin
                    r_res.status <= ST_RANGE;
                end else begin
                    r_res.status <= ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/suim_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// suim_back
// Runs both directions side by side on a queued job and holds the result
// in an output register.
// ----------------------------------------------------------------------------
module suim_back
    import suim_pkg::*;
#(
    parameter int MARKER_COUNT_BITS = MARKER_COUNT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_job_valid,
    input  wire t_job                       i_job,
    input  wire logic [MARKER_COUNT_BITS:0] i_tx_cnt,
    input  wire logic [MARKER_COUNT_BITS:0] i_rx_cnt,
    output logic                            o_job_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output t_out                            o_data
);

    t_chan_flags tx_flags;
    t_chan_flags rx_flags;
    t_chan_res   tx_res;
    t_chan_res   rx_res;
    logic        start;
    logic        ack;
    logic        r_out_valid;
    t_out        r_out;

    assign start = i_job_valid && !tx_flags.busy && !rx_flags.busy;
    assign ack   = tx_flags.done && rx_flags.done && (!r_out_valid || !i_stall);

    suim_chan #(
        .MARKER_COUNT_BITS(MARKER_COUNT_BITS)
    ) u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_job.tx),
        .i_cnt   (i_tx_cnt),
        .i_ack   (ack),
        .o_flags (tx_flags),
        .o_res   (tx_res)
    );

    suim_chan #(
        .MARKER_COUNT_BITS(MARKER_COUNT_BITS)
    ) u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_job.rx),
        .i_cnt   (i_rx_cnt),
        .i_ack   (ack),
        .o_flags (rx_flags),
        .o_res   (rx_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ack) begin
            r_out.tx_unit_interval <= tx_res.ui;
            r_out.tx_status        <= tx_res.status;
            if (tx_res.status == ST_OK) begin
                r_out.rx_unit_interval <= rx_res.ui;
                r_out.rx_status        <= rx_res.status;
            end else begin
                r_out.rx_unit_interval <= '0;
                r_out.rx_status        <= ST_SKIP;
            end
        end
    end

    assign o_job_pop = start;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

endmodule
`default_nettype wire

[hdl/serdes_unit_interval_measure_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// serdes_unit_interval_measure_core
// Serdes TX/RX unit interval measurement from marker timestamp snapshots.
// ----------------------------------------------------------------------------
// An accepted snapshot pair is classified at once and placed in a two-entry
// queue, so the input keeps taking items while the back end is busy, until
// the queue is full. In the back end TX and RX run in parallel, and each
// runs a bit-serial divider twice (58 steps per division), which sets the
// sustained rate. Results leave through an output register.
// Configuration is applied to an item when it is accepted.
module serdes_unit_interval_measure_core
    import suim_pkg::*;
#(
    parameter int MARKER_COUNT_BITS = MARKER_COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = MARKER_COUNT_BITS + 1;
    localparam int QW = $bits(t_job) + 2 * CW;

    logic [SPEED_W-1:0] r_speed_mode;
    logic               r_rx_kr_fec;
    logic [LANES_W-1:0] r_lanes_used;

    t_job          f_job;
    logic [CW-1:0] f_tx_cnt;
    logic [CW-1:0] f_rx_cnt;
    logic          q_full;
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          q_pop;
    logic          push;
    t_job          b_job;
    logic [CW-1:0] b_tx_cnt;
    logic [CW-1:0] b_rx_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_mode <= SPEED_10G;
            r_rx_kr_fec  <= 1'b0;
            r_lanes_used <= LANES_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPEED_MODE: r_speed_mode <= i_cfg_data[SPEED_W-1:0];
                CFG_RX_KR_FEC:  r_rx_kr_fec  <= i_cfg_data[0];
                CFG_LANES_USED: r_lanes_used <= i_cfg_data[LANES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    suim_front #(
        .MARKER_COUNT_BITS(MARKER_COUNT_BITS)
    ) u_front (
        .i_data       (i_in_data),
        .i_speed_mode (r_speed_mode),
        .i_rx_kr_fec  (r_rx_kr_fec),
        .i_lanes_used (r_lanes_used),
        .o_job        (f_job),
        .o_tx_cnt     (f_tx_cnt),
        .o_rx_cnt     (f_rx_cnt)
    );

    assign push       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    suim_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_job, f_tx_cnt, f_rx_cnt}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {b_job, b_tx_cnt, b_rx_cnt} = q_data;

    suim_back #(
        .MARKER_COUNT_BITS(MARKER_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (b_job),
        .i_tx_cnt    (b_tx_cnt),
        .i_rx_cnt    (b_rx_cnt),
        .o_job_pop   (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule
`default_nettype wire
